FILE: rtl/core/i2cbw_pkg.sv
`default_nettype none

package i2cbw_pkg;

  // Value of the address register after reset: slave address 0x27 with the write bit.
  localparam logic [7:0] ADDR_RESET = 8'h4E;

  // Bit counter value of the acknowledge clock that follows the eight data bits.
  localparam logic [3:0] ACK_BIT = 4'd8;

  // Index of the final SCL pulse of a recovery request (nine pulses in all).
  localparam logic [3:0] LAST_PULSE = 4'd8;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic sda_low;
    logic scl_high;
    logic last;
  } out_item_t;

  typedef enum logic {
    CMD_WRITE   = 1'b0,
    CMD_RECOVER = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] bytes;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_head_t;

  typedef struct packed {
    logic busy;
    logic emit_last;
  } back_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/i2c_bitbang_write_sequencer.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_item_t: op, data_byte
// out       output     out_valid/out_stall  out_item_t: sda_low, scl_high, last
// cfg       input      cfg_valid/cfg_ready  cfg_data: address byte
//
// One pin state is produced per cycle while the output is not stalled, as set by the
// bit sequencer in the back end. Back-to-back requests follow without a gap; the
// first state of a request goes through the state register, then the output
// register. A two-entry request queue lets the input run ahead of the pins.
// Synchronous reset empties the queue, idles the sequencer and sets the address
// to 0x4E. A stalled output holds the sequencer; in_stall rises when the queue is full.
`default_nettype none

module i2c_bitbang_write_sequencer
  import i2cbw_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  wire        out_stall,
  output out_item_t  out_data,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [7:0]  cfg_data
);

  queue_head_t head;
  logic        pop;
  back_stat_t  stat;

  i2cbw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .pop       (pop),
    .head      (head)
  );

  i2cbw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .stat      (stat)
  );

`ifndef NO_ASSERTIONS
  // Every request ends on a stop condition: SDA released with SCL high.
  a_last_is_stop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.last) |-> (!out_data.sda_low && out_data.scl_high))
    else $error("final pin state is not a stop condition");

  // A request leaves the queue only when the sequencer is free for it.
  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> (head.valid && (!stat.busy || stat.emit_last)))
    else $error("request taken while the sequencer is busy");

  // The queue can only fill through an accepted request.
  a_stall_after_push: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid))
    else $error("queue became full without a request");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/i2cbw_front.sv
`default_nettype none

module i2cbw_front
  import i2cbw_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire [7:0]   cfg_data,
  input  wire         pop,
  output queue_head_t head
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [7:0]       address_byte;
  entry_t           mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             do_pop;
  entry_t           new_entry;

  assign cfg_ready = 1'b1;
  assign in_stall  = (count == CNT_W'(QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign do_pop    = pop && (count != '0);

  // The address is bound to the request when it is queued.
  always_comb begin
    new_entry.cmd   = in_data.op ? CMD_RECOVER : CMD_WRITE;
    new_entry.bytes = {address_byte, in_data.data_byte};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address_byte <= ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      address_byte <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_comb begin
    head.valid = (count != '0);
    head.entry = mem[rd_ptr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/i2cbw_back.sv
`default_nettype none

module i2cbw_back
  import i2cbw_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  queue_head_t head,
  output logic        pop,
  output logic        out_valid,
  input  wire         out_stall,
  output out_item_t   out_data,
  output back_stat_t  stat
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_BYTE  = 5'b00100,
    S_PULSE = 5'b01000,
    S_STOP  = 5'b10000
  } state_t;

  state_t      state, state_next;
  logic [1:0]  sub, sub_next;
  logic [3:0]  bit_cnt, bit_cnt_next;
  logic        byte_sel, byte_sel_next;
  logic [15:0] shift, shift_next;

  logic cur_sda;
  logic cur_scl;
  logic cur_last;
  logic adv;
  logic load;

  assign adv  = (state != S_IDLE) && (!out_valid || !out_stall);
  // A queued request starts in the cycle the previous one emits its final state.
  assign load = head.valid && ((state == S_IDLE) || (adv && cur_last));
  assign pop  = load;

  always_comb begin
    cur_sda  = 1'b0;
    cur_scl  = 1'b0;
    cur_last = 1'b0;
    unique case (state)
      S_IDLE: begin
      end
      S_START: begin
        cur_sda = (sub != 2'd0);
        cur_scl = (sub != 2'd2);
      end
      S_BYTE: begin
        cur_sda = (bit_cnt == ACK_BIT) ? 1'b0 : !shift[15];
        cur_scl = (sub == 2'd1);
      end
      S_PULSE: begin
        cur_scl = (sub == 2'd1);
      end
      S_STOP: begin
        cur_sda  = (sub != 2'd2);
        cur_scl  = (sub != 2'd0);
        cur_last = (sub == 2'd2);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next    = state;
    sub_next      = sub;
    bit_cnt_next  = bit_cnt;
    byte_sel_next = byte_sel;
    shift_next    = shift;
    if (adv) begin
      unique case (state)
        S_START: begin
          if (sub == 2'd2) begin
            state_next    = S_BYTE;
            sub_next      = 2'd0;
            bit_cnt_next  = 4'd0;
            byte_sel_next = 1'b0;
          end else begin
            sub_next = sub + 2'd1;
          end
        end
        S_BYTE: begin
          if (sub == 2'd2) begin
            sub_next = 2'd0;
            if (bit_cnt == ACK_BIT) begin
              if (!byte_sel) begin
                byte_sel_next = 1'b1;
                bit_cnt_next  = 4'd0;
              end else begin
                state_next = S_STOP;
              end
            end else begin
              bit_cnt_next = bit_cnt + 4'd1;
              shift_next   = {shift[14:0], 1'b0};
            end
          end else begin
            sub_next = sub + 2'd1;
          end
        end
        S_PULSE: begin
          if (sub == 2'd1) begin
            sub_next = 2'd0;
            if (bit_cnt == LAST_PULSE) begin
              state_next = S_STOP;
            end else begin
              bit_cnt_next = bit_cnt + 4'd1;
            end
          end else begin
            sub_next = sub + 2'd1;
          end
        end
        S_STOP: begin
          if (sub == 2'd2) begin
            state_next = S_IDLE;
          end else begin
            sub_next = sub + 2'd1;
          end
        end
        default: begin
        end
      endcase
    end
    if (load) begin
      state_next    = (head.entry.cmd == CMD_WRITE) ? S_START : S_PULSE;
      sub_next      = 2'd0;
      bit_cnt_next  = 4'd0;
      byte_sel_next = 1'b0;
      shift_next    = head.entry.bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sub       <= 2'd0;
      bit_cnt   <= 4'd0;
      byte_sel  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      sub      <= sub_next;
      bit_cnt  <= bit_cnt_next;
      byte_sel <= byte_sel_next;
      if (adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    shift <= shift_next;
    if (adv) begin
      out_data.sda_low  <= cur_sda;
      out_data.scl_high <= cur_scl;
      out_data.last     <= cur_last;
    end
  end

  always_comb begin
    stat.busy      = (state != S_IDLE);
    stat.emit_last = adv && cur_last;
  end

endmodule

`default_nettype wire
